### rtl/absolute_tape_block_loader_top_macros.svh
// assertion macros shared by the tape loader rtl
// expects clk_i and rst_ni in the including module
`ifndef ABSOLUTE_TAPE_BLOCK_LOADER_TOP_MACROS_SVH
`define ABSOLUTE_TAPE_BLOCK_LOADER_TOP_MACROS_SVH

// same-cycle implication
`define ATBL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ATBL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/atbl_pkg.sv
// types and constants of the tape block loader
// no dependencies
`default_nettype none

package atbl_pkg;

  localparam int unsigned AddrBits = 16;
  localparam logic [16:0] AddrSpace = 17'(1 << AddrBits);
  localparam logic [15:0] HeaderBytes = 16'd6;
  localparam logic [16:0] LimitReset = 17'd57344;
  localparam logic [2:0] RegLimitAddr = 3'd0;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SIGNATURE = 3'd1,
    ERR_SHORT_LEN = 3'd2,
    ERR_RANGE     = 3'd3,
    ERR_CHECKSUM  = 3'd4,
    ERR_TRUNCATED = 3'd5
  } err_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       command;
    logic [7:0] tape_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] exec_address;
    logic        exec_found;
    logic        halt_requested;
    logic [2:0]  error_code;
  } res_t;

endpackage

`default_nettype wire

### rtl/absolute_tape_block_loader_top.sv
// Absolute-format tape block loader. Takes one tape transaction per cycle
// (a tape byte or an end-of-tape mark) and returns at most one result per
// transaction: a memory write, a clean finish with the exec address, or a
// sticky error. Results are registered as their input is taken; a
// two-entry output buffer keeps input flowing at one transaction per cycle
// while the consumer keeps up, and input stalls only when both entries wait.
// The memory limit register sits at APB address 0 and resets to 57344.
// depends on atbl_pkg, atbl_parser and atbl_skid
`default_nettype none

module absolute_tape_block_loader_top (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire atbl_pkg::item_t in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output atbl_pkg::res_t       out_data_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [16:0]    limit_q;
  logic           space;
  logic           res_valid;
  atbl_pkg::res_t res;
  logic           reg_sel;

  assign pready     = 1'b1;
  assign reg_sel    = paddr == atbl_pkg::RegLimitAddr;
  assign prdata     = reg_sel ? {15'd0, limit_q} : 32'd0;
  assign in_ready_o = space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= atbl_pkg::LimitReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      limit_q <= pwdata[16:0];
    end
  end

  atbl_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (space),
    .item_i      (in_data_i),
    .limit_i     (limit_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  atbl_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid & in_valid_i & space),
    .data_i      (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/atbl_parser.sv
// block parser: header, data, checksum and end-of-tape handling
// depends on atbl_pkg and the assertion macro header
`default_nettype none

`include "absolute_tape_block_loader_top_macros.svh"

module atbl_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_ready_i,
  input  wire atbl_pkg::item_t  item_i,
  input  wire logic [16:0]      limit_i,
  output logic                  res_valid_o,
  output atbl_pkg::res_t        res_o
);

  typedef enum logic [2:0] {
    PH_SIG1 = 3'd0,
    PH_SIG2 = 3'd1,
    PH_LEN1 = 3'd2,
    PH_LEN2 = 3'd3,
    PH_ADR1 = 3'd4,
    PH_ADR2 = 3'd5,
    PH_DATA = 3'd6,
    PH_CSUM = 3'd7
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] lp_q, lp_d;
  logic [15:0] exec_q, exec_d;
  logic        seen_q, seen_d;
  logic [7:0]  sum_q, sum_d;
  logic [2:0]  fault_q, fault_d;

  logic        accept;
  logic [7:0]  b;
  logic [7:0]  sum_n;
  logic [15:0] len;
  logic [15:0] addr;
  logic [15:0] rem_m1;
  logic [16:0] limit_eff;

  assign accept    = in_valid_i & in_ready_i;
  assign b         = item_i.tape_byte;
  assign sum_n     = sum_q + b;
  assign len       = {b, rem_q[7:0]};
  assign addr      = {b, lp_q[7:0]};
  assign rem_m1    = rem_q - 16'd1;
  assign limit_eff = (limit_i > atbl_pkg::AddrSpace) ? atbl_pkg::AddrSpace : limit_i;

  always_comb begin
    phase_d     = phase_q;
    rem_d       = rem_q;
    lp_d        = lp_q;
    exec_d      = exec_q;
    seen_d      = seen_q;
    sum_d       = sum_q;
    fault_d     = fault_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (item_i.command == atbl_pkg::CMD_END) begin
      res_valid_o = 1'b1;
      if (fault_q != atbl_pkg::ERR_NONE) begin
        res_o.result_kind = atbl_pkg::KIND_ERROR;
        res_o.error_code  = fault_q;
      end else if (phase_q != PH_SIG1) begin
        fault_d           = atbl_pkg::ERR_TRUNCATED;
        res_o.result_kind = atbl_pkg::KIND_ERROR;
        res_o.error_code  = atbl_pkg::ERR_TRUNCATED;
      end else begin
        res_o.result_kind    = atbl_pkg::KIND_DONE;
        res_o.exec_found     = seen_q;
        res_o.exec_address   = seen_q ? exec_q : 16'd0;
        res_o.halt_requested = seen_q & exec_q[0];
      end
    end else if (fault_q == atbl_pkg::ERR_NONE) begin
      sum_d = sum_n;
      case (phase_q)
        PH_SIG1: begin
          if (b == 8'd1) begin
            phase_d = PH_SIG2;
          end else if (b != 8'd0) begin
            fault_d = atbl_pkg::ERR_SIGNATURE;
          end
        end
        PH_SIG2: begin
          if (b != 8'd0) begin
            fault_d = atbl_pkg::ERR_SIGNATURE;
          end else begin
            phase_d = PH_LEN1;
          end
        end
        PH_LEN1: begin
          rem_d   = {8'd0, b};
          phase_d = PH_LEN2;
        end
        PH_LEN2: begin
          if (len < atbl_pkg::HeaderBytes) begin
            rem_d   = len;
            fault_d = atbl_pkg::ERR_SHORT_LEN;
          end else begin
            rem_d   = len - atbl_pkg::HeaderBytes;
            phase_d = PH_ADR1;
          end
        end
        PH_ADR1: begin
          lp_d    = {8'd0, b};
          phase_d = PH_ADR2;
        end
        PH_ADR2: begin
          if (rem_q == 16'd0) begin
            exec_d  = addr;
            seen_d  = 1'b1;
            lp_d    = 16'd0;
            phase_d = PH_CSUM;
          end else begin
            lp_d    = addr;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          if ({1'b0, lp_q} >= limit_eff) begin
            fault_d = atbl_pkg::ERR_RANGE;
          end else begin
            res_o.result_kind   = atbl_pkg::KIND_WRITE;
            res_o.write_address = lp_q;
            res_o.write_data    = b;
            lp_d                = lp_q + 16'd1;
            rem_d               = rem_m1;
            if (rem_m1 == 16'd0) begin
              phase_d = PH_CSUM;
            end
          end
          res_valid_o = 1'b1;
        end
        PH_CSUM: begin
          if (sum_n != 8'd0) begin
            fault_d = atbl_pkg::ERR_CHECKSUM;
          end else begin
            rem_d   = 16'd0;
            lp_d    = 16'd0;
            sum_d   = 8'd0;
            phase_d = PH_SIG1;
          end
        end
        default: begin
          phase_d = PH_SIG1;
        end
      endcase
      if (fault_d != atbl_pkg::ERR_NONE) begin
        res_valid_o       = 1'b1;
        res_o             = '0;
        res_o.result_kind = atbl_pkg::KIND_ERROR;
        res_o.error_code  = fault_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG1;
      rem_q   <= 16'd0;
      lp_q    <= 16'd0;
      exec_q  <= 16'd0;
      seen_q  <= 1'b0;
      sum_q   <= 8'd0;
      fault_q <= atbl_pkg::ERR_NONE;
    end else if (accept) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      lp_q    <= lp_d;
      exec_q  <= exec_d;
      seen_q  <= seen_d;
      sum_q   <= sum_d;
      fault_q <= fault_d;
    end
  end

  `ATBL_ASSERT_NXT(a_fault_sticky, fault_q != atbl_pkg::ERR_NONE, fault_q == $past(fault_q), "fault code changed after a fault")
  `ATBL_ASSERT_IMP(a_data_nonempty, phase_q == PH_DATA && fault_q == atbl_pkg::ERR_NONE, rem_q != 16'd0, "data phase with no bytes left")
  `ATBL_ASSERT_NXT(a_error_records, accept && res_valid_o && res_o.result_kind == atbl_pkg::KIND_ERROR, fault_q != atbl_pkg::ERR_NONE, "error result without stored fault")

endmodule

`default_nettype wire

### rtl/atbl_skid.sv
// two-entry result buffer between parser and output channel
// depends on atbl_pkg and the assertion macro header
`default_nettype none

`include "absolute_tape_block_loader_top_macros.svh"

module atbl_skid (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire atbl_pkg::res_t  data_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output atbl_pkg::res_t       out_data_o
);

  atbl_pkg::res_t mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     count_q;
  logic           pop;

  assign space_o     = count_q != 2'd2;
  assign out_valid_o = count_q != 2'd0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  `ATBL_ASSERT_IMP(a_no_overflow, count_q == 2'd2, !push_i, "push into a full buffer")
  `ATBL_ASSERT_IMP(a_count_range, 1'b1, count_q != 2'd3, "buffer count out of range")
  `ATBL_ASSERT_NXT(a_out_hold, out_valid_o && !pop, $stable(out_data_o), "stalled result changed")

endmodule

`default_nettype wire
